// ----- src/vmt_pkg.sv -----
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the 4x4 Q16.16 matrix-vector transform unit.
// ----------------------------------------------------------------------------
package vmt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_STAGES = 5;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_XFORM   = 2'd1,
        OP_XFORM_T = 2'd2
    } op_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [3:0] vec_t;
    typedef vec_t  [3:0] mat_t;

    typedef struct packed {
        op_t                      operation;
        logic [1:0]               row_index;
        logic signed [WORD_W-1:0] in_x;
        logic signed [WORD_W-1:0] in_y;
        logic signed [WORD_W-1:0] in_z;
        logic signed [WORD_W-1:0] in_w;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] out_w;
        logic                     overflow;
    } res_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  out_valid;
    } pipe_ctl_t;

endpackage

// ----- src/vec4_mat4_transform_unit.sv -----
// ----------------------------------------------------------------------------
// vec4_mat4_transform_unit
// 4x4 Q16.16 matrix times 4-component vector, plain or transposed.
// ----------------------------------------------------------------------------
// Takes one command per cycle while cmd_ready is high. A load command writes
// one matrix row at the transfer and produces no result; every transform
// accepted afterwards sees the new row. A transform produces one result,
// registered through the pipeline: operand capture, 16 parallel 32x32
// multipliers, two adder-tree levels, shift/saturate output register.
// Results leave in command order; backpressure on res_ready stalls the
// pipeline stage by stage with no loss.
module vec4_mat4_transform_unit
    import vmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    pipe_ctl_t ctl;
    mat_t      coeff;
    vec_t      vec;
    word_t     lane_res [4];
    logic      lane_sat [4];
    logic      xfer;
    logic      load_row;
    logic      enter;

    assign xfer     = cmd_valid && cmd_ready;
    assign load_row = xfer && (cmd.operation == OP_LOAD);
    assign enter    = xfer && ((cmd.operation == OP_XFORM) || (cmd.operation == OP_XFORM_T));

    assign vec[0] = cmd.in_x;
    assign vec[1] = cmd.in_y;
    assign vec[2] = cmd.in_z;
    assign vec[3] = cmd.in_w;

    vmt_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .enter     (enter),
        .out_ready (res_ready),
        .in_ready  (cmd_ready),
        .ctl       (ctl)
    );

    vmt_matrix_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (load_row),
        .wr_row     (cmd.row_index),
        .wr_data    (vec),
        .transposed (cmd.operation == OP_XFORM_T),
        .coeff      (coeff)
    );

    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        vmt_dot_lane u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .vec    (vec),
            .coeff  (coeff[j]),
            .result (lane_res[j]),
            .sat    (lane_sat[j])
        );
    end

    assign res_valid    = ctl.out_valid;
    assign res.out_x    = lane_res[0];
    assign res.out_y    = lane_res[1];
    assign res.out_z    = lane_res[2];
    assign res.out_w    = lane_res[3];
    assign res.overflow = lane_sat[0] || lane_sat[1] || lane_sat[2] || lane_sat[3];

endmodule

// ----- src/vmt_matrix_store.sv -----
// ----------------------------------------------------------------------------
// vmt_matrix_store
// 4x4 coefficient matrix, row-wide writes, per-lane column or row select.
// ----------------------------------------------------------------------------
module vmt_matrix_store
    import vmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_row,
    input  vec_t       wr_data,
    input  logic       transposed,
    output mat_t       coeff
);

    mat_t m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else if (wr_en)
        begin
            m_reg[wr_row] <= wr_data;
        end
    end

    // coeff[j][i]: weight of vector element i in output j
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                coeff[j][i] = transposed ? m_reg[j][i] : m_reg[i][j];
            end
        end
    end

endmodule

// ----- src/vmt_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// vmt_pipe_ctrl
// Valid bits and stall propagation for the transform pipeline.
// ----------------------------------------------------------------------------
module vmt_pipe_ctrl
    import vmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enter,
    input  logic      out_ready,
    output logic      in_ready,
    output pipe_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;

    always_comb
    begin
        rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = enter;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready      = rdy[0];
    assign ctl.load      = rdy[NUM_STAGES-1:0];
    assign ctl.out_valid = valid_reg[NUM_STAGES-1];

endmodule

// ----- src/vmt_dot_lane.sv -----
// ----------------------------------------------------------------------------
// vmt_dot_lane
// One output component: four products, adder tree, shift and saturate.
// ----------------------------------------------------------------------------
module vmt_dot_lane
    import vmt_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  vec_t      vec,
    input  vec_t      coeff,
    output word_t     result,
    output logic      sat
);

    localparam int HI_W = SUM_W - FRAC_BITS - WORD_W + 1;

    vec_t                     v_reg;
    vec_t                     c_reg;
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PROD_W-1:0] prod_next [4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    word_t                    res_reg;
    word_t                    res_next;
    logic                     sat_reg;
    logic                     sat_next;
    logic [HI_W-1:0]          hi;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = PROD_W'(v_reg[i]) * PROD_W'(c_reg[i]);
        end
        for (int p = 0; p < 2; p++)
        begin
            pair_next[p] = PAIR_W'(prod_reg[2*p]) + PAIR_W'(prod_reg[2*p+1]);
        end
        sum_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end

    // floor shift; in range when all bits from the result's sign upward agree
    always_comb
    begin
        hi       = sum_reg[SUM_W-1:FRAC_BITS+WORD_W-1];
        sat_next = !((&hi) || !(|hi));
        if (!sat_next)
        begin
            res_next = sum_reg[FRAC_BITS+WORD_W-1:FRAC_BITS];
        end
        else if (sum_reg[SUM_W-1])
        begin
            res_next = WORD_MIN;
        end
        else
        begin
            res_next = WORD_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            v_reg <= vec;
            c_reg <= coeff;
        end
        if (ctl.load[1])
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (ctl.load[2])
        begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (ctl.load[3])
        begin
            sum_reg <= sum_next;
        end
        if (ctl.load[4])
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign result = res_reg;
    assign sat    = sat_reg;

endmodule

// ----- src/vmt_checker.sv -----
// ----------------------------------------------------------------------------
// vmt_checker
// Port-level checks for the transform unit, bound to the top level.
// ----------------------------------------------------------------------------
module vmt_checker
    import vmt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res))
        else $error("result changed while stalled");

    // overflow only with a clamped component
    a_ovf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflow |->
            (res.out_x == WORD_MAX) || (res.out_x == WORD_MIN) ||
            (res.out_y == WORD_MAX) || (res.out_y == WORD_MIN) ||
            (res.out_z == WORD_MAX) || (res.out_z == WORD_MIN) ||
            (res.out_w == WORD_MAX) || (res.out_w == WORD_MIN))
        else $error("overflow without saturated component");

    // a result out of an empty pipeline traces back to a transform transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |->
            $past(cmd_valid && cmd_ready &&
                  ((cmd.operation == OP_XFORM) || (cmd.operation == OP_XFORM_T)), 5))
        else $error("result without matching transform transfer");

endmodule

bind vec4_mat4_transform_unit vmt_checker u_chk (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: 4x4 matrix-vector transform unit testbench
// Drives row loads, plain/transposed transforms and unused codes through the command
// channel, keeps a shadow copy of the matrix, predicts each Q16.16 result
// with exact 66-bit sums, floor shift and 32-bit saturation, and compares
// every result transfer field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import vmt_pkg::*;

    localparam op_t   OP_NONE      = op_t'(2'd3);   // unused code, ignored by the block
    localparam int    RANDOM_ITEMS = 2000;
    localparam word_t Q_ONE        = 32'sh0001_0000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    cmd_t  pending_cmds[$];
    res_t  expected_results[$];
    word_t shadow_mat[4][4];
    int    accepted_count = 0;
    int    error_count    = 0;
    int    total_cmds;
    int    send_gap   = 0;
    int    stall_left = 0;
    bit    drv_burst  = 1'b0;
    bit    mon_burst  = 1'b0;

    vec4_mat4_transform_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #4 clk = ~clk;

    // exact dot product, floor shift, clamp to 32 bits
    function automatic word_t dot_saturate(input word_t a[4], input word_t b[4],
                                           inout logic sat);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] prod;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            prod = a[i] * b[i];
            acc  = acc + prod;
        end
        acc = acc >>> FRAC_BITS;
        if (acc[SUM_W-1:WORD_W-1] == '0 || acc[SUM_W-1:WORD_W-1] == '1)
            return acc[WORD_W-1:0];
        sat = 1'b1;
        return acc[SUM_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    task automatic apply_command(input cmd_t c);
        word_t vin[4];
        word_t col[4];
        word_t outw[4];
        logic  sat;
        res_t  r;
        vin = '{c.in_x, c.in_y, c.in_z, c.in_w};
        sat = 1'b0;
        case (c.operation)
            OP_LOAD:
                for (int i = 0; i < 4; i++)
                    shadow_mat[c.row_index][i] = vin[i];
            OP_XFORM, OP_XFORM_T: begin
                for (int j = 0; j < 4; j++) begin
                    for (int i = 0; i < 4; i++)
                        col[i] = (c.operation == OP_XFORM) ? shadow_mat[i][j]
                                                           : shadow_mat[j][i];
                    outw[j] = dot_saturate(vin, col, sat);
                end
                r.out_x    = outw[0];
                r.out_y    = outw[1];
                r.out_z    = outw[2];
                r.out_w    = outw[3];
                r.overflow = sat;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: %p", got);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("out_x", want.out_x, got.out_x);
        compare_field("out_y", want.out_y, got.out_y);
        compare_field("out_z", want.out_z, got.out_z);
        compare_field("out_w", want.out_w, got.out_w);
        compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
    endtask

    task automatic queue_cmd(input op_t op, input logic [1:0] row,
                             input word_t x, input word_t y, input word_t z, input word_t w);
        cmd_t c;
        c.operation = op;
        c.row_index = row;
        c.in_x      = x;
        c.in_y      = y;
        c.in_z      = z;
        c.in_w      = w;
        pending_cmds.push_back(c);
    endtask

    function automatic word_t random_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return word_t'($urandom_range(0, 2)) - 32'sd1;
            12, 13, 14, 15: return word_t'($urandom());
            default: return word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic build_directed();
        // empty matrix after reset
        queue_cmd(OP_XFORM, 2'd0, WORD_MAX, WORD_MIN, Q_ONE, -Q_ONE);
        // identity
        for (int i = 0; i < 4; i++)
            queue_cmd(OP_LOAD, 2'(i), (i == 0) ? Q_ONE : 32'sd0, (i == 1) ? Q_ONE : 32'sd0,
                      (i == 2) ? Q_ONE : 32'sd0, (i == 3) ? Q_ONE : 32'sd0);
        queue_cmd(OP_XFORM,   2'd3, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1);
        queue_cmd(OP_XFORM_T, 2'd2, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1);
        // asymmetric row so plain and transposed differ
        queue_cmd(OP_LOAD, 2'd0, Q_ONE, 32'sh0002_0000, 32'sh0003_0000, -32'sh0004_0000);
        queue_cmd(OP_XFORM,   2'd0, Q_ONE, -32'sh0000_8000, 32'sh0000_4000, 32'sh0002_0000);
        queue_cmd(OP_XFORM_T, 2'd1, Q_ONE, -32'sh0000_8000, 32'sh0000_4000, 32'sh0002_0000);
        // floor of a negative fraction
        queue_cmd(OP_LOAD, 2'd3, 32'sd1, 32'sd1, 32'sd0, 32'sd0);
        queue_cmd(OP_XFORM, 2'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1);
        // saturation both ways
        queue_cmd(OP_LOAD, 2'd1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        queue_cmd(OP_LOAD, 2'd2, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_cmd(OP_XFORM,   2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        queue_cmd(OP_XFORM,   2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_cmd(OP_XFORM_T, 2'd2, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_cmd(OP_XFORM_T, 2'd3, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        // unused code must leave the matrix alone
        queue_cmd(OP_NONE, 2'd1, WORD_MIN, WORD_MAX, -32'sd1, 32'sd0);
        queue_cmd(OP_NONE, 2'd2, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_cmd(OP_XFORM,   2'd3, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_cmd(OP_XFORM_T, 2'd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    endtask

    task automatic build_random();
        int  counted;
        int  r;
        op_t op;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                op = OP_LOAD;
            else if (r < 62)
                op = OP_XFORM;
            else if (r < 94)
                op = OP_XFORM_T;
            else
                op = OP_NONE;
            queue_cmd(op, 2'($urandom_range(0, 3)), random_word(), random_word(),
                      random_word(), random_word());
            if (op != OP_NONE)
                counted++;
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            send_gap  <= 0;
        end
        else begin
            if (cmd_valid && cmd_ready) begin
                apply_command(cmd);
                accepted_count <= accepted_count + 1;
            end
            if (!cmd_valid || cmd_ready) begin
                if (send_gap > 0) begin
                    send_gap  <= send_gap - 1;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0) begin
                    cmd       <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    send_gap  <= pick_gap(drv_burst);
                end
                else begin
                    cmd_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 199) == 0)
                drv_burst <= !drv_burst;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end
        else begin
            if (res_valid && res_ready)
                check_result(res);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else begin
                res_ready  <= 1'b1;
                stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap(mon_burst) : 0;
            end
            if ($urandom_range(0, 199) == 0)
                mon_burst <= !mon_burst;
        end
    end

    initial begin
        build_directed();
        build_random();
        total_cmds = pending_cmds.size();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                shadow_mat[r][c] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_count < total_cmds)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_STAGES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/vmt_pkg.sv
src/vmt_matrix_store.sv
src/vmt_pipe_ctrl.sv
src/vmt_dot_lane.sv
src/vec4_mat4_transform_unit.sv
src/vmt_checker.sv
bench/tb_top.sv
